### hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define CPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

### hw/rtl/cpa_pkg.sv
// Shared types, codes and defaults for the contiguous page allocator.
// No dependencies.
package cpa_pkg;

    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 13;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FLAG_W   = 2;
    localparam int REG_IDX_W = 1;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd1;

    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;

    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = '0;
    localparam logic [COUNT_W-1:0] PAGES_IN_USE_RST = 13'd4096;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0]  page_count;
        logic [ADDR_W-1:0]   address;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address_res;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [COUNT_W-1:0] pages_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIPE,
        S_SCAN,
        S_MARK,
        S_FREE
    } state_t;

endpackage

### hw/rtl/cpa_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module cpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cpa_cfg_regs.sv
// Configuration registers: base address and managed page count.
// Depends on cpa_pkg.
module cpa_cfg_regs
    import cpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS: cfg_next.base_address = cfg_data;
                REG_PAGES_IN_USE: cfg_next.pages_in_use = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= BASE_ADDRESS_RST;
            cfg_reg.pages_in_use <= PAGES_IN_USE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/cpa_engine.sv
// Request sequencer: first-fit scan, run marking, free walk and flag wipe
// over the flag RAM. Depends on cpa_pkg.
module cpa_engine
    import cpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  cmd_t                         cmd,
    input  cfg_t                         cfg,
    output logic                         busy,
    output logic                         done,
    output rsp_t                         rsp,
    output logic                         ram_we,
    output logic [$clog2(NUM_PAGES)-1:0] ram_waddr,
    output logic [FLAG_W-1:0]            ram_wdata,
    output logic [$clog2(NUM_PAGES)-1:0] ram_raddr,
    input  logic [FLAG_W-1:0]            ram_rdata
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] LAST_PAGE = CNT_W'(NUM_PAGES - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pvld_reg, pvld_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [CNT_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic             wipe_reply_reg, wipe_reply_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    logic [CMP_W-1:0]  avail_w;
    logic [CMP_W-1:0]  req_cnt;
    logic [CNT_W-1:0]  avail;
    logic              cnt_bad;
    logic [ADDR_W-1:0] free_off;
    logic [ADDR_W-1:0] free_idx;
    logic              free_ok;
    logic              taken;
    logic              last_flag;
    logic [CNT_W-1:0]  len_inc;
    logic [CNT_W-1:0]  pidx_inc;
    logic              hit;
    logic              at_end;
    logic              issue;
    logic [ADDR_W-1:0] alloc_addr;

    assign avail_w   = (CMP_W'(cfg.pages_in_use) < CMP_W'(NUM_PAGES)) ?
                       CMP_W'(cfg.pages_in_use) : CMP_W'(NUM_PAGES);
    assign avail     = avail_w[CNT_W-1:0];
    assign req_cnt   = CMP_W'(cmd.page_count);
    assign cnt_bad   = (req_cnt == '0) || (req_cnt > avail_w);
    assign free_off  = cmd.address - cfg.base_address;
    assign free_idx  = free_off >> PAGE_SHIFT;
    assign free_ok   = free_idx < ADDR_W'(avail);

    assign taken     = (ram_rdata & FLAG_TAKEN) != FLAG_NONE;
    assign last_flag = (ram_rdata & FLAG_LAST) != FLAG_NONE;
    assign len_inc   = run_len_reg + 1'b1;
    assign pidx_inc  = pidx_reg + 1'b1;
    assign hit       = pvld_reg && !taken && (len_inc == count_reg);
    assign at_end    = pidx_inc == avail;
    assign issue     = ptr_reg < avail;
    assign alloc_addr = cfg.base_address + (ADDR_W'(run_start_reg) << PAGE_SHIFT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.action)
                        ACT_ALLOC: state_next = cnt_bad ? S_IDLE : S_SCAN;
                        ACT_FREE:  state_next = free_ok ? S_FREE : S_IDLE;
                        ACT_CLEAR: state_next = S_WIPE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WIPE:
            begin
                if (ptr_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_MARK;
                end
                else if (pvld_reg && at_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                if (ptr_reg == end_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (pvld_reg && (!taken || last_flag || at_end))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        ptr_next        = ptr_reg;
        pvld_next       = pvld_reg;
        pidx_next       = pidx_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        count_next      = count_reg;
        end_next        = end_reg;
        wipe_reply_next = wipe_reply_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg[IDX_W-1:0];
        ram_wdata       = FLAG_NONE;
        ram_raddr       = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rsp_next.address_res = '0;
                    rsp_next.status      = ST_BAD;
                    unique case (cmd.action)
                        ACT_ALLOC:
                        begin
                            if (cnt_bad)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next       = '0;
                                pvld_next      = 1'b0;
                                run_len_next   = '0;
                                run_start_next = '0;
                                count_next     = req_cnt[CNT_W-1:0];
                            end
                        end
                        ACT_FREE:
                        begin
                            if (free_ok)
                            begin
                                ptr_next  = free_idx[CNT_W-1:0];
                                pvld_next = 1'b0;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            ptr_next        = '0;
                            wipe_reply_next = 1'b1;
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            S_WIPE:
            begin
                ram_we    = 1'b1;
                ram_wdata = FLAG_NONE;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == LAST_PAGE)
                begin
                    done_next            = wipe_reply_reg;
                    rsp_next.status      = ST_DONE;
                    rsp_next.address_res = '0;
                    wipe_reply_next      = 1'b0;
                end
            end
            S_SCAN:
            begin
                pvld_next = issue;
                pidx_next = ptr_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (pvld_reg)
                begin
                    if (taken)
                    begin
                        run_len_next   = '0;
                        run_start_next = pidx_inc;
                    end
                    else if (hit)
                    begin
                        ptr_next = run_start_reg;
                        end_next = pidx_reg;
                    end
                    else
                    begin
                        run_len_next = len_inc;
                    end
                    if (!hit && at_end)
                    begin
                        done_next            = 1'b1;
                        rsp_next.status      = ST_NOFIT;
                        rsp_next.address_res = '0;
                    end
                end
            end
            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = (ptr_reg == end_reg) ? (FLAG_TAKEN | FLAG_LAST) : FLAG_TAKEN;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == end_reg)
                begin
                    done_next            = 1'b1;
                    rsp_next.status      = ST_DONE;
                    rsp_next.address_res = alloc_addr;
                end
            end
            S_FREE:
            begin
                pvld_next = issue;
                pidx_next = ptr_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (pvld_reg)
                begin
                    ram_waddr = pidx_reg[IDX_W-1:0];
                    ram_we    = taken;
                    if (!taken || last_flag || at_end)
                    begin
                        done_next            = 1'b1;
                        rsp_next.status      = ST_DONE;
                        rsp_next.address_res = '0;
                    end
                end
            end
            default: done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_WIPE;
            ptr_reg        <= '0;
            pvld_reg       <= 1'b0;
            wipe_reply_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pvld_reg       <= pvld_next;
            wipe_reply_reg <= wipe_reply_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        run_len_reg   <= run_len_next;
        run_start_reg <= run_start_next;
        count_reg     <= count_next;
        end_reg       <= end_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### hw/rtl/contiguous_page_allocator.sv
// Top level of the first-fit contiguous page allocator.
// Depends on cpa_pkg, cpa_ram, cpa_cfg_regs, cpa_engine, assert_macros.svh.
//
//  channel   | handshake          | word
//  ----------+--------------------+------------------------------------
//  request   | start, busy        | cmd  (action, page_count, address)
//  result    | done (strobe)      | rsp  (status, address_res)
//  config    | cfg_we, cfg_index  | cfg_data
//
// Refused requests answer in the cycle after start. Allocate primes one read, then
// checks one page per cycle over at most min(pages_in_use, NUM_PAGES) pages and
// marks one page per cycle. Free primes one read, then clears one page per cycle
// up to the last page of the run, a free page or the end of the managed pages.
// Clear and reset both sweep all NUM_PAGES entries, one per cycle, busy high.
// Results are strobed for one cycle; the receiver cannot stall them.
`include "assert_macros.svh"

module contiguous_page_allocator
    import cpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(NUM_PAGES);

    cfg_t              cfg;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [FLAG_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [FLAG_W-1:0] ram_rdata;

    cpa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpa_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (NUM_PAGES)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpa_engine #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .cfg       (cfg),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    `CPA_ASSERT_NXT(a_req_answered, clk, rst_n, start && !busy, busy || done)
    `CPA_ASSERT_IMP(a_status_code, clk, rst_n, done, rsp.status <= ST_BAD)
    `CPA_ASSERT_IMP(a_fail_addr_zero, clk, rst_n, done && rsp.status != ST_DONE, rsp.address_res == '0)
    `CPA_ASSERT_NXT(a_done_ends_work, clk, rst_n, done, !$past(busy, 2) || !busy || $past(start))

endmodule
